// ----- src/lkvc_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
// Used by lkvc_ctrl, lkvc_datapath and lru_key_value_cache.
package lkvc_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int DATA_WIDTH_DEFAULT = 32;
	localparam int KEY_W              = 32;
	localparam int WORD_W             = 32;
	localparam int OP_W               = 3;
	localparam int COUNT_W            = 5;
	localparam int CAP_W              = 5;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_GET      = 3'd0,
		OP_ADD      = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_CONTAINS = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic signed [KEY_W-1:0] key;
		logic [WORD_W-1:0] data_in;
	} request_t;

	typedef struct packed {
		logic               found;
		logic [WORD_W-1:0]  read_data;
		logic [COUNT_W-1:0] item_count;
	} result_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic promote;
		logic drop;
		logic insert;
		logic clear;
		logic read;
	} cmd_t;

	typedef struct packed {
		logic hit;
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_EXEC,
		ST_RESP
	} state_t;

endpackage

// ----- src/lkvc_ctrl.sv -----
// Controller for the LRU key/value cache: sequences match, update and response.
// Depends on lkvc_pkg; drives lkvc_datapath through cmd_t.
module lkvc_ctrl import lkvc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] operation,
	input  status_t         status,
	output logic            busy,
	output logic            done,
	output logic            found,
	output cmd_t            cmd
);

	state_t          state_q, state_d;
	logic [OP_W-1:0] op_q;
	logic            found_q, found_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation;
		end
		if (state_q == ST_EXEC) begin
			found_q <= found_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b0;
		done    = 1'b0;
		found_d = 1'b0;
		unique case (state_q)
			ST_IDLE, ST_RESP: begin
				done = (state_q == ST_RESP);
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_MATCH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MATCH: begin
				busy       = 1'b1;
				cmd.lookup = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				busy    = 1'b1;
				state_d = ST_RESP;
				case (op_q)
					OP_GET: begin
						cmd.promote = status.hit;
						cmd.read    = status.hit;
						found_d     = status.hit;
					end
					OP_ADD: begin
						cmd.promote = status.hit;
						cmd.insert  = !status.hit;
						found_d     = 1'b1;
					end
					OP_REMOVE: begin
						cmd.drop = status.hit;
						found_d  = status.hit;
					end
					OP_CONTAINS: begin
						found_d = status.hit;
					end
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						found_d   = 1'b1;
					end
					default: begin
						found_d = 1'b0;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign found = found_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held for two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction did not start");

	a_exec_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> done) else $error("update not followed by result");

endmodule

// ----- src/lkvc_datapath.sv -----
// Datapath for the LRU key/value cache: key match, age ranks, count and data store.
// Depends on lkvc_pkg; commanded by lkvc_ctrl.
module lkvc_datapath import lkvc_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEFAULT,
	parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  request_t           request,
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_data,
	output status_t            status,
	output logic [WORD_W-1:0]  read_data,
	output logic [COUNT_W-1:0] item_count
);

	localparam int RW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0]      cap_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_WIDTH-1:0] din_q;

	logic [DEPTH-1:0]      valid_q;
	logic [KEY_W-1:0]      key_arr_q [DEPTH];
	logic [RW-1:0]         rank_q    [DEPTH];
	logic [CW-1:0]         count_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;
	logic                  rd_ok_q;

	logic [DEPTH-1:0]      hit_vec_s1, lru_vec_s1;
	logic [RW-1:0]         hit_idx_s1, hit_rank_s1, ins_idx_s1;
	logic                  evict_s1;

	logic [DEPTH-1:0]      hit_vec, lru_vec, free_vec;
	logic [RW-1:0]         hit_idx, hit_rank, ins_idx, lru_rank;
	logic [CMPW-1:0]       cap_ext, cap_c;
	logic                  evict;

	always_comb begin
		cap_ext = CMPW'(cap_q);
		if (cap_ext == '0) begin
			cap_c = CMPW'(1);
		end else if (cap_ext > CMPW'(DEPTH)) begin
			cap_c = CMPW'(DEPTH);
		end else begin
			cap_c = cap_ext;
		end
		evict    = (CMPW'(count_q) >= cap_c);
		lru_rank = RW'(count_q - CW'(1));
		hit_idx  = '0;
		hit_rank = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (key_arr_q[i] == key_q);
			lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
			if (hit_vec[i]) begin
				hit_idx  = hit_idx | RW'(i);
				hit_rank = hit_rank | rank_q[i];
			end
		end
		free_vec = ~valid_q | (evict ? lru_vec : '0);
		ins_idx  = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				ins_idx = RW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAPACITY_RESET;
			valid_q <= '0;
			count_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.lookup) begin
				rd_ok_q <= 1'b0;
			end else if (cmd.read) begin
				rd_ok_q <= 1'b1;
			end
			if (cmd.clear) begin
				valid_q <= '0;
				count_q <= '0;
			end else if (cmd.drop) begin
				valid_q[hit_idx_s1] <= 1'b0;
				count_q             <= count_q - CW'(1);
			end else if (cmd.insert) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (RW'(i) == ins_idx_s1) begin
						valid_q[i] <= 1'b1;
					end else if (evict_s1 && lru_vec_s1[i]) begin
						valid_q[i] <= 1'b0;
					end
				end
				if (!evict_s1) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= request.key;
			din_q <= DATA_WIDTH'(request.data_in);
		end
		if (cmd.lookup) begin
			hit_vec_s1  <= hit_vec;
			lru_vec_s1  <= lru_vec;
			hit_idx_s1  <= hit_idx;
			hit_rank_s1 <= hit_rank;
			ins_idx_s1  <= ins_idx;
			evict_s1    <= evict;
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.promote && valid_q[i]) begin
				if (hit_vec_s1[i]) begin
					rank_q[i] <= '0;
				end else if (rank_q[i] < hit_rank_s1) begin
					rank_q[i] <= rank_q[i] + RW'(1);
				end
			end else if (cmd.drop && valid_q[i] && rank_q[i] > hit_rank_s1) begin
				rank_q[i] <= rank_q[i] - RW'(1);
			end else if (cmd.insert) begin
				if (RW'(i) == ins_idx_s1) begin
					rank_q[i]    <= '0;
					key_arr_q[i] <= key_q;
				end else if (valid_q[i] && !(evict_s1 && lru_vec_s1[i])) begin
					rank_q[i] <= rank_q[i] + RW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			mem[ins_idx_s1] <= din_q;
		end
		if (cmd.read) begin
			rd_q <= mem[hit_idx_s1];
		end
	end

	assign status.hit = |hit_vec_s1;
	assign read_data  = rd_ok_q ? WORD_W'(rd_q) : '0;
	assign item_count = COUNT_W'(count_q);

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q)) else $error("count disagrees with valid entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("count above depth");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |=> $onehot0(hit_vec_s1)) else $error("key held by two entries");

endmodule

// ----- src/lru_key_value_cache.sv -----
// A fully associative key/data cache kept in recency order. A transaction is
// accepted when start is high and busy is low; its result shows on result with
// done high for exactly one cycle, after the match and update steps, and cannot be
// held off. A new transaction may be accepted in the cycle its predecessor's
// result is shown, but not before it: the match step registers the parallel key
// match and the least recent and free slot search, then the update step applies
// the age-rank, valid and data-store update.
// Top level; depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
module lru_key_value_cache import lkvc_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEFAULT,
	parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  request_t         request,
	output logic             done,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.status    (status),
		.busy      (busy),
		.done      (done),
		.found     (result.found),
		.cmd       (cmd)
	);

	lkvc_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.request    (request),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.status     (status),
		.read_data  (result.read_data),
		.item_count (result.item_count)
	);

endmodule

// ----- test/lru_key_value_cache_tb.sv -----
// Self-checking testbench for lru_key_value_cache: directed and random cache transactions
// with randomized idle gaps, checked against a class-based shadow of the recency-ordered store.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
	import lkvc_pkg::*;

	localparam int SLOTS           = DEPTH_DEFAULT;
	localparam int ITEMS_PER_PHASE = 155;
	localparam int PHASES          = 12;
	localparam int PLANNED_PHASES  = 10;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int POOL_MAX        = 24;
	localparam int EXTREME_KEYS    = 4;
	localparam logic [OP_W-1:0] OP_TOP_CODE = {OP_W{1'b1}};

	class lru_shadow;
		logic [CAP_W-1:0]  capacity;
		bit                valid [SLOTS];
		logic [KEY_W-1:0]  keys [SLOTS];
		logic [WORD_W-1:0] words [SLOTS];
		int unsigned       rank [SLOTS];
		int unsigned       count;
		result_t           pending_results [$];
		int                errors;
		int                results_seen;
		int                found_seen;

		function new();
			capacity = CAPACITY_RESET;
			foreach (valid[i]) valid[i] = 1'b0;
			count = 0;
			errors = 0;
			results_seen = 0;
			found_seen = 0;
		endfunction

		function int unsigned limit();
			if (capacity == 0) return 1;
			if (capacity > SLOTS) return SLOTS;
			return capacity;
		endfunction

		function int slot_of(logic [KEY_W-1:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (valid[i] && keys[i] == k) return i;
			return -1;
		endfunction

		function void promote(int s);
			for (int i = 0; i < SLOTS; i++)
				if (valid[i] && rank[i] < rank[s]) rank[i]++;
			rank[s] = 0;
		endfunction

		function void evict(int s);
			int unsigned r;
			r = rank[s];
			valid[s] = 1'b0;
			for (int i = 0; i < SLOTS; i++)
				if (valid[i] && rank[i] > r) rank[i]--;
			if (count > 0) count--;
		endfunction

		function int oldest();
			int best;
			best = -1;
			for (int i = 0; i < SLOTS; i++)
				if (valid[i] && (best < 0 || rank[i] > rank[best])) best = i;
			return best;
		endfunction

		function void note_request(request_t req);
			result_t r;
			int s;
			r = '0;
			case (req.operation)
				OP_GET: begin
					s = slot_of(req.key);
					if (s >= 0) begin
						promote(s);
						r.found = 1'b1;
						r.read_data = words[s];
					end
				end
				OP_ADD: begin
					r.found = 1'b1;
					s = slot_of(req.key);
					if (s >= 0) begin
						promote(s);
					end else begin
						if (count >= limit()) begin
							s = oldest();
							if (s >= 0) evict(s);
						end
						s = -1;
						for (int i = 0; i < SLOTS; i++)
							if (!valid[i] && s < 0) s = i;
						if (s >= 0) begin
							foreach (valid[i]) if (valid[i]) rank[i]++;
							valid[s] = 1'b1;
							keys[s] = req.key;
							words[s] = req.data_in;
							rank[s] = 0;
							count++;
						end
					end
				end
				OP_REMOVE: begin
					s = slot_of(req.key);
					if (s >= 0) begin
						evict(s);
						r.found = 1'b1;
					end
				end
				OP_CONTAINS: begin
					r.found = (slot_of(req.key) >= 0);
				end
				OP_CLEAR: begin
					foreach (valid[i]) valid[i] = 1'b0;
					count = 0;
					r.found = 1'b1;
				end
				default: begin
				end
			endcase
			r.item_count = count[COUNT_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with none pending: found=%0b data=%h count=%0d",
					$time, got.found, got.read_data, got.item_count);
				return;
			end
			want = pending_results.pop_front();
			results_seen++;
			if (want.found) found_seen++;
			if (got.found !== want.found || got.read_data !== want.read_data ||
					got.item_count !== want.item_count) begin
				errors++;
				$display("%0t: mismatch: expected found=%0b data=%h count=%0d, got found=%0b data=%h count=%0d",
					$time, want.found, want.read_data, want.item_count,
					got.found, got.read_data, got.item_count);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	request_t         request;
	logic             done;
	result_t          result;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_data;

	lru_shadow        shadow = new();
	int unsigned      cycles = 0;
	bit               quiet = 1'b0;
	logic [KEY_W-1:0] key_pool [POOL_MAX];
	int               pool_size = EXTREME_KEYS;
	logic [CAP_W-1:0] cap_plan [PLANNED_PHASES] = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17,
		5'd5, 5'd16, 5'd3, 5'd8, 5'd12};

	lru_key_value_cache #(
		.DEPTH(SLOTS),
		.DATA_WIDTH(DATA_WIDTH_DEFAULT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time, shadow.pending_results.size());
			$display("lru_key_value_cache_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) shadow.check_result(result);
	end

	function automatic request_t make_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [WORD_W-1:0] d);
		request_t r;
		r.operation = op;
		r.key = k;
		r.data_in = d;
		return r;
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int p;
		p = $urandom_range(0, 99);
		if (p < 34) return OP_ADD;
		if (p < 60) return OP_GET;
		if (p < 73) return OP_REMOVE;
		if (p < 88) return OP_CONTAINS;
		if (p < 91) return OP_CLEAR;
		return OP_W'($urandom_range(OP_CLEAR + 1, OP_TOP_CODE));
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 5) return $urandom;
		return key_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	task automatic hold_off();
		int p;
		int n;
		p = $urandom_range(0, 99);
		if (quiet || p < 60) n = 0;
		else if (p < 92) n = $urandom_range(1, 3);
		else n = $urandom_range(8, 40);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send(request_t req);
		@(negedge clk);
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy !== 1'b0);
		shadow.note_request(req);
		hold_off();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (shadow.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow.capacity = v;
	endtask

	initial begin
		logic [CAP_W-1:0] cap;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		send(make_req(OP_CONTAINS, 32'h0000_0000, 32'h0));
		send(make_req(OP_GET, 32'h8000_0000, 32'hffff_ffff));
		send(make_req(OP_REMOVE, 32'h0000_0005, 32'h0));
		send(make_req(OP_ADD, 32'h8000_0000, 32'h0000_0000));
		send(make_req(OP_ADD, 32'h7fff_ffff, 32'hffff_ffff));
		send(make_req(OP_ADD, 32'h0000_0000, 32'ha5a5_a5a5));
		send(make_req(OP_ADD, 32'hffff_ffff, 32'h5a5a_5a5a));
		send(make_req(OP_GET, 32'h8000_0000, 32'h0));
		send(make_req(OP_GET, 32'h7fff_ffff, 32'h0));
		send(make_req(OP_GET, 32'hffff_ffff, 32'h0));
		send(make_req(OP_ADD, 32'h0000_0000, 32'h1234_5678));
		send(make_req(OP_GET, 32'h0000_0000, 32'h0));
		send(make_req(OP_CONTAINS, 32'h7fff_ffff, 32'h0));
		send(make_req(OP_REMOVE, 32'h7fff_ffff, 32'h0));
		send(make_req(OP_REMOVE, 32'h7fff_ffff, 32'h0));
		send(make_req(OP_CONTAINS, 32'h7fff_ffff, 32'h0));
		send(make_req(OP_W'(OP_CLEAR + 1), 32'h0000_0000, 32'hffff_ffff));
		send(make_req(OP_W'(OP_CLEAR + 2), 32'hffff_ffff, 32'h0));
		send(make_req(OP_TOP_CODE, 32'h8000_0000, 32'h0));
		send(make_req(OP_CLEAR, 32'h0000_0000, 32'h0));
		send(make_req(OP_GET, 32'h0000_0000, 32'h0));
		send(make_req(OP_ADD, 32'h1234_5678, 32'hdead_beef));

		for (int p = 0; p < PHASES; p++) begin
			cap = (p < PLANNED_PHASES) ? cap_plan[p] : CAP_W'($urandom_range(0, 31));
			set_capacity(cap);
			quiet = (p % 4 == 2);
			pool_size = shadow.limit() + 4;
			if (pool_size > POOL_MAX) pool_size = POOL_MAX;
			for (int i = EXTREME_KEYS; i < POOL_MAX; i++) key_pool[i] = $urandom;
			repeat (ITEMS_PER_PHASE) send(make_req(pick_op(), pick_key(), $urandom));
		end

		wait_drained();
		$display("checked %0d results over %0d capacity settings, %0d of them reporting found",
			shadow.results_seen, PHASES + 1, shadow.found_seen);
		if (shadow.errors == 0) begin
			$display("lru_key_value_cache_tb: PASS");
		end else begin
			$display("%0d mismatches", shadow.errors);
			$display("lru_key_value_cache_tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/lkvc_pkg.sv
src/lkvc_ctrl.sv
src/lkvc_datapath.sv
src/lru_key_value_cache.sv
test/lru_key_value_cache_tb.sv
